// ===== rtl/npmq_pkg.sv =====
// shared constants, types and codes for the negacyclic polynomial multiplier
package npmq_pkg;

  localparam int COEFFS     = 8;
  localparam int COEF_BITS  = 18;
  localparam int MOD_BITS   = 18;
  localparam int IDX_BITS   = $clog2(COEFFS);
  localparam int CNT_BITS   = $clog2(COEFFS + 1);
  localparam int BREG_BITS  = COEF_BITS + 1;
  localparam int PROD_BITS  = COEF_BITS + BREG_BITS;
  localparam int ACC_BITS   = PROD_BITS + IDX_BITS;
  localparam int STEP_BITS  = $clog2(ACC_BITS + 1);

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(97);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_PREP,
    ST_REDUCE,
    ST_FIX,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic mul;
    logic clear;
    logic acc;
    logic prep;
    logic shift;
    logic fix;
    logic drain;
  } cell_ctrl_t;

endpackage

// ===== rtl/npmq_cell.sv =====
// one cell of the chain: operand pair, exact accumulator, serial modular reducer
module npmq_cell import npmq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  cell_ctrl_t                  ctrl,
  input  logic                        load_sel,
  input  logic signed [COEF_BITS-1:0] a_load,
  input  logic signed [COEF_BITS-1:0] b_load,
  input  logic signed [COEF_BITS-1:0] a_up,
  input  logic signed [COEF_BITS-1:0] a_bcast,
  input  logic signed [BREG_BITS-1:0] b_prev,
  input  logic signed [COEF_BITS-1:0] res_up,
  input  logic        [MOD_BITS-1:0]  modulus,
  output logic signed [COEF_BITS-1:0] a_out,
  output logic signed [BREG_BITS-1:0] b_out,
  output logic signed [COEF_BITS-1:0] res_out
);

  logic signed [COEF_BITS-1:0] areg;
  logic signed [BREG_BITS-1:0] breg;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic        [MOD_BITS-1:0]  rem;
  logic                        neg;
  logic signed [COEF_BITS-1:0] res;

  logic        [MOD_BITS:0]    trial;
  logic        [MOD_BITS:0]    mod_ext;
  logic        [MOD_BITS-1:0]  rem_next;
  logic        [MOD_BITS-1:0]  rem_fold;
  logic        [MOD_BITS-1:0]  half;
  logic        [MOD_BITS:0]    centred;
  logic signed [COEF_BITS-1:0] res_next;

  // restoring reduction step, one magnitude bit per cycle
  always_comb begin
    mod_ext  = {1'b0, modulus};
    trial    = {rem, acc[ACC_BITS-1]};
    rem_next = (trial >= mod_ext) ? MOD_BITS'(trial - mod_ext) : trial[MOD_BITS-1:0];
  end

  // sign fold and centring
  always_comb begin
    rem_fold = (neg && rem != '0) ? modulus - rem : rem;
    half     = (modulus - MOD_BITS'(1)) >> 1;
    centred  = (rem_fold > half) ? {1'b0, rem_fold} - mod_ext : {1'b0, rem_fold};
    res_next = (modulus == '0) ? '0 : COEF_BITS'($signed(centred));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      areg <= '0;
      breg <= '0;
      acc  <= '0;
    end else begin
      if (load_sel) begin
        areg <= a_load;
        breg <= BREG_BITS'(b_load);
      end else if (ctrl.mul) begin
        areg <= a_up;
        breg <= ctrl.clear ? '0 : b_prev;
      end
      priority if (ctrl.acc) begin
        acc <= acc + ACC_BITS'(prod);
      end else if (ctrl.prep) begin
        acc <= acc[ACC_BITS-1] ? -acc : acc;
      end else if (ctrl.shift) begin
        acc <= acc << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= a_bcast * breg;
    end
    if (ctrl.prep) begin
      neg <= acc[ACC_BITS-1];
      rem <= '0;
    end else if (ctrl.shift) begin
      rem <= rem_next;
    end
    if (ctrl.fix) begin
      res <= res_next;
    end else if (ctrl.drain) begin
      res <= res_up;
    end
  end

  assign a_out   = areg;
  assign b_out   = breg;
  assign res_out = res;

endmodule

// ===== rtl/npmq_seq.sv =====
// sequencer: load count, phase state machine and cell control
module npmq_seq import npmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_last,
  output cell_ctrl_t        ctrl,
  output logic [COEFFS-1:0] load_sel
);

  state_t               state, state_next;
  logic [STEP_BITS-1:0] step, step_next;
  logic [CNT_BITS-1:0]  load_count, load_count_next;
  logic                 pending, pending_next;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      step       <= '0;
      load_count <= '0;
      pending    <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      load_count <= load_count_next;
      pending    <= pending_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    load_count_next = load_count;
    pending_next    = pending;
    ctrl            = '0;
    out_valid       = 1'b0;
    out_last        = 1'b0;
    load_sel        = '0;
    in_stall        = !((state == ST_LOAD || state == ST_DRAIN) && !pending);
    accept          = in_valid && !in_stall;

    // pairs beyond the store depth are dropped
    if (accept && load_count < CNT_BITS'(COEFFS)) begin
      load_sel        = COEFFS'(1) << load_count[IDX_BITS-1:0];
      load_count_next = load_count + 1'b1;
    end

    unique case (state)
      ST_LOAD: begin
        if (accept && in_last) begin
          state_next = ST_MAC;
          step_next  = '0;
        end
      end
      ST_MAC: begin
        ctrl.mul   = step < STEP_BITS'(COEFFS);
        ctrl.clear = step == STEP_BITS'(COEFFS - 1);
        ctrl.acc   = step != '0;
        if (step == STEP_BITS'(COEFFS - 1)) begin
          load_count_next = '0;
        end
        if (step == STEP_BITS'(COEFFS)) begin
          state_next = ST_PREP;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_PREP: begin
        ctrl.prep  = 1'b1;
        state_next = ST_REDUCE;
        step_next  = '0;
      end
      ST_REDUCE: begin
        ctrl.shift = 1'b1;
        if (step == STEP_BITS'(ACC_BITS - 1)) begin
          state_next = ST_FIX;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_FIX: begin
        ctrl.fix   = 1'b1;
        state_next = ST_DRAIN;
        step_next  = '0;
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        out_last  = step == STEP_BITS'(COEFFS - 1);
        if (accept && in_last) begin
          pending_next = 1'b1;
        end
        if (!out_stall) begin
          ctrl.drain = 1'b1;
          if (out_last) begin
            state_next   = (pending || (accept && in_last)) ? ST_MAC : ST_LOAD;
            pending_next = 1'b0;
            step_next    = '0;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/negacyclic_poly_multiply_mod_q.sv =====
// top level: negacyclic polynomial multiplier over a chain of cells, modulo q
// sequence: once the item flagged last is taken, the mac, prep, reduce and fix phases
//   run in that order, then the results drain
// throughput: one pair per cycle while loading, COEFFS results one per cycle while out_stall is low; a
//   new product starts its mac phase only after the last one has drained, the bit-serial reducer setting most of it
// new pairs are taken while results drain; rst (synchronous) clears stores, count, modulus 97
module negacyclic_poly_multiply_mod_q import npmq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  // modulus write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [MOD_BITS-1:0]  cfg_data,
  // coefficient pair items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COEF_BITS-1:0] a_coef,
  input  logic signed [COEF_BITS-1:0] b_coef,
  input  logic                        last_coef,
  // product coefficient items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COEF_BITS-1:0] result_coef,
  output logic                        last_result
);

  logic [MOD_BITS-1:0] modulus;
  cell_ctrl_t          ctrl;
  logic [COEFFS-1:0]   load_sel;

  // neighbor links of the chain
  logic signed [COEF_BITS-1:0] a_chain   [COEFFS];
  logic signed [BREG_BITS-1:0] b_chain   [COEFFS];
  logic signed [COEF_BITS-1:0] res_chain [COEFFS];
  logic signed [COEF_BITS-1:0] a_up      [COEFFS];
  logic signed [BREG_BITS-1:0] b_prev    [COEFFS];
  logic signed [COEF_BITS-1:0] res_up    [COEFFS];

  // the user changes modulus only while idle (not enforced here); no handshake back-pressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  npmq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last_coef),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_last  (last_result),
    .ctrl      (ctrl),
    .load_sel  (load_sel)
  );

  // a moves toward cell 0 and is broadcast from there; b rotates upward, the
  // coefficient wrapping past the top comes back negated (x^COEFFS = -1)
  assign b_prev[0] = -b_chain[COEFFS-1];

  for (genvar k = 0; k < COEFFS; k++) begin : g_cell
    if (k == COEFFS - 1) begin : g_top
      assign a_up[k]   = '0;
      assign res_up[k] = '0;
    end else begin : g_mid
      assign a_up[k]   = a_chain[k+1];
      assign res_up[k] = res_chain[k+1];
    end
    if (k != 0) begin : g_link
      assign b_prev[k] = b_chain[k-1];
    end

    npmq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .load_sel (load_sel[k]),
      .a_load   (a_coef),
      .b_load   (b_coef),
      .a_up     (a_up[k]),
      .a_bcast  (a_chain[0]),
      .b_prev   (b_prev[k]),
      .res_up   (res_up[k]),
      .modulus  (modulus),
      .a_out    (a_chain[k]),
      .b_out    (b_chain[k]),
      .res_out  (res_chain[k])
    );
  end

  // results leave from cell 0 in ascending degree
  assign result_coef = res_chain[0];

endmodule

// ===== rtl/npmq_checker.sv =====
// port-level checker for the multiplier and its bind
module npmq_checker import npmq_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        last_coef,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [COEF_BITS-1:0] result_coef,
  input logic                        last_result
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_coef) && $stable(last_result))
    else $error("result item changed under stall");

  // a product never shows up right after its start item
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_coef && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after start");

  // the drain runs without gaps until the final coefficient
  a_drain_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_result |=> out_valid)
    else $error("gap inside result burst");

  // nothing follows the final coefficient directly
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> !out_valid)
    else $error("result after final coefficient");

endmodule

bind negacyclic_poly_multiply_mod_q npmq_checker u_npmq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .last_coef   (last_coef),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_coef (result_coef),
  .last_result (last_result)
);
